### design/hafbf_pkg.sv
// Shared types and codes for the hole allocator (first fit / best fit).
// No dependencies; used by hole_allocator_first_best_fit.
`timescale 1ns / 1ps
`default_nettype none

package hafbf_pkg;

  typedef logic [1:0]  cmd_code_t;
  typedef logic [1:0]  status_code_t;
  typedef logic [3:0]  hole_idx_t;
  typedef logic [15:0] size_field_t;
  typedef logic [4:0]  hole_count_t;
  typedef logic        cfg_index_t;

  localparam cmd_code_t CMD_LOAD    = 2'd0;
  localparam cmd_code_t CMD_ALLOC   = 2'd1;
  localparam cmd_code_t CMD_RESTORE = 2'd2;

  localparam status_code_t ST_OK        = 2'd0;
  localparam status_code_t ST_NO_FIT    = 2'd1;
  localparam status_code_t ST_BAD_INDEX = 2'd2;

  localparam cfg_index_t CFG_HOLE_COUNT = 1'b0;
  localparam cfg_index_t CFG_FIT_MODE   = 1'b1;

  localparam int CFG_DATA_W = 5;

  typedef struct packed {
    cmd_code_t   cmd;
    hole_idx_t   hole_slot;
    size_field_t hole_size;
    size_field_t request_size;
  } in_item_t;

  typedef struct packed {
    status_code_t status;
    logic         granted;
    hole_idx_t    chosen_hole;
    size_field_t  left_in_hole;
  } out_item_t;

endpackage

`default_nettype wire

### design/hole_allocator_first_best_fit.sv
// Hole allocator top level: hole tables in two sync memories, scan sequencer.
// Depends on hafbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A load, or any command other than allocate and restore, is answered without a scan:
// busy stays low and the result strobes in the cycle after start. Allocate and
// restore walk the holes in use (N = min(hole_count, NUM_HOLES)) one memory read
// per cycle: busy stays high through the scan and the finish state, and the
// result strobes in the first cycle with busy low again; with N = 0 they finish
// like a load. out_valid is a one-cycle strobe and cannot be held off, so the
// receiver must take every beat. The user must write configuration only while
// busy is low and no result is pending; the block itself does not enforce this.
module hole_allocator_first_best_fit #(
  parameter int NUM_HOLES = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  hafbf_pkg::in_item_t              in_data,
  output logic                             out_valid,
  output hafbf_pkg::out_item_t             out_data,
  input  wire                              cfg_we,
  input  hafbf_pkg::cfg_index_t            cfg_index,
  input  wire [hafbf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_HOLES);
  localparam int CNT_W = $clog2(NUM_HOLES + 1);
  localparam int HC_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int SL_W  = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  // configuration
  hafbf_pkg::hole_count_t hole_count_r;
  logic                   fit_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_count_r <= '0;
      fit_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hafbf_pkg::CFG_HOLE_COUNT: hole_count_r <= cfg_wdata[4:0];
        hafbf_pkg::CFG_FIT_MODE:   fit_mode_r   <= cfg_wdata[0];
      endcase
    end
  end

  logic [CNT_W-1:0] count_eff;
  always_comb begin
    if (HC_W'(hole_count_r) > HC_W'(NUM_HOLES)) count_eff = CNT_W'(NUM_HOLES);
    else                                        count_eff = CNT_W'(hole_count_r);
  end

  // sequencer state
  state_t                 state_r;
  hafbf_pkg::cmd_code_t   cmd_r;
  logic [SIZE_BITS-1:0]   req_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       scan_idx_r;
  logic                   issue_r;
  logic                   d_vld_r;
  logic                   d_last_r;
  logic [IDX_W-1:0]       d_idx_r;
  logic                   found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [SIZE_BITS-1:0]   best_val_r;
  logic                   out_valid_r;
  hafbf_pkg::out_item_t   out_data_r;

  // memories and valid bits (an entry never loaded reads as zero)
  logic [SIZE_BITS-1:0] orig_mem [NUM_HOLES];
  logic [SIZE_BITS-1:0] rem_mem  [NUM_HOLES];
  logic [NUM_HOLES-1:0] valid_r;
  logic [SIZE_BITS-1:0] orig_q_r;
  logic [SIZE_BITS-1:0] rem_q_r;
  logic                 ent_vld_q_r;

  logic                 accept;
  logic                 load_ok;
  logic                 go_scan;
  logic [IDX_W-1:0]     load_addr;
  logic [SIZE_BITS-1:0] load_size;
  logic [SIZE_BITS-1:0] cur_orig;
  logic [SIZE_BITS-1:0] cur_rem;
  logic [SIZE_BITS-1:0] new_left;
  logic                 take;
  logic                 last_issue;
  logic                 rem_we;
  logic [IDX_W-1:0]     rem_wa;
  logic [SIZE_BITS-1:0] rem_wd;
  hafbf_pkg::status_code_t quick_status;
  hafbf_pkg::out_item_t    fin_data;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign load_ok   = SL_W'(in_data.hole_slot) < SL_W'(count_eff);
  assign load_addr = IDX_W'(in_data.hole_slot);
  assign load_size = SIZE_BITS'(in_data.hole_size);
  assign go_scan   = ((in_data.cmd == hafbf_pkg::CMD_ALLOC) ||
                      (in_data.cmd == hafbf_pkg::CMD_RESTORE)) && (count_eff != '0);

  assign cur_orig   = ent_vld_q_r ? orig_q_r : '0;
  assign cur_rem    = ent_vld_q_r ? rem_q_r  : '0;
  assign new_left   = best_val_r - req_r;
  assign last_issue = (CNT_W'(scan_idx_r + 1'b1) == count_r);
  assign take       = (cur_rem >= req_r) &&
                      (!found_r || (fit_mode_r && (cur_rem < best_val_r)));

  // status of a command answered without a scan
  always_comb begin
    priority if ((in_data.cmd == hafbf_pkg::CMD_LOAD) && !load_ok) begin
      quick_status = hafbf_pkg::ST_BAD_INDEX;
    end else if (in_data.cmd == hafbf_pkg::CMD_ALLOC) begin
      quick_status = hafbf_pkg::ST_NO_FIT;
    end else begin
      quick_status = hafbf_pkg::ST_OK;
    end
  end

  // result beat at the end of a scan
  always_comb begin
    fin_data = '0;
    if ((cmd_r == hafbf_pkg::CMD_ALLOC) && found_r) begin
      fin_data.granted      = 1'b1;
      fin_data.chosen_hole  = hafbf_pkg::hole_idx_t'(best_idx_r);
      fin_data.left_in_hole = hafbf_pkg::size_field_t'(new_left);
    end else if (cmd_r == hafbf_pkg::CMD_ALLOC) begin
      fin_data.status = hafbf_pkg::ST_NO_FIT;
    end
  end

  // single write port on the remaining-size table
  always_comb begin
    rem_we = 1'b0;
    rem_wa = load_addr;
    rem_wd = load_size;
    priority if (accept && (in_data.cmd == hafbf_pkg::CMD_LOAD) && load_ok) begin
      rem_we = 1'b1;
    end else if ((state_r == S_SCAN) && d_vld_r && (cmd_r == hafbf_pkg::CMD_RESTORE)) begin
      rem_we = 1'b1;
      rem_wa = d_idx_r;
      rem_wd = cur_orig;
    end else if ((state_r == S_FINISH) && (cmd_r == hafbf_pkg::CMD_ALLOC) && found_r) begin
      rem_we = 1'b1;
      rem_wa = best_idx_r;
      rem_wd = new_left;
    end else begin
      rem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.cmd == hafbf_pkg::CMD_LOAD) && load_ok) begin
      orig_mem[load_addr] <= load_size;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    orig_q_r    <= orig_mem[scan_idx_r[IDX_W-1:0]];
    rem_q_r     <= rem_mem[scan_idx_r[IDX_W-1:0]];
    ent_vld_q_r <= valid_r[scan_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (accept && (in_data.cmd == hafbf_pkg::CMD_LOAD) && load_ok) begin
      valid_r[load_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      d_last_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          d_vld_r     <= 1'b0;
          d_last_r    <= 1'b0;
          out_valid_r <= accept && !go_scan;
          if (accept) begin
            cmd_r      <= in_data.cmd;
            req_r      <= SIZE_BITS'(in_data.request_size);
            count_r    <= count_eff;
            scan_idx_r <= '0;
            found_r    <= 1'b0;
            out_data_r <= {quick_status, 1'b0, hafbf_pkg::hole_idx_t'(0),
                           hafbf_pkg::size_field_t'(0)};
            if (go_scan) begin
              state_r <= S_SCAN;
              issue_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          out_valid_r <= 1'b0;
          if (issue_r) begin
            scan_idx_r <= CNT_W'(scan_idx_r + 1'b1);
            if (last_issue) issue_r <= 1'b0;
          end
          d_vld_r  <= issue_r;
          d_last_r <= issue_r && last_issue;
          d_idx_r  <= scan_idx_r[IDX_W-1:0];
          if (d_vld_r && (cmd_r == hafbf_pkg::CMD_ALLOC) && take) begin
            found_r    <= 1'b1;
            best_idx_r <= d_idx_r;
            best_val_r <= cur_rem;
          end
          if (d_vld_r && d_last_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_data_r  <= fin_data;
          d_vld_r     <= 1'b0;
          d_last_r    <= 1'b0;
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
